// File: hw/rtl/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// Bank decoder package
// Shared widths, codes, the decoded-access record and the flag function.
// ----------------------------------------------------------------------------
package hcbd_pkg;

   localparam int ADDR_W     = 16;
   localparam int DATA_W     = 8;
   localparam int COLOR_AW   = 10;
   localparam int COLOR_DW   = 4;
   localparam int ROUTE_W    = 4;
   localparam int FLAG_W     = 4;
   localparam int CSR_IDX_W  = 1;

   localparam logic [DATA_W-1:0] PORT_DIR_RESET  = 8'h2F;
   localparam logic [DATA_W-1:0] PORT_DATA_RESET = 8'h1F;

   localparam int FLAG_KERNAL = 0;
   localparam int FLAG_BASIC  = 1;
   localparam int FLAG_CHAR   = 2;
   localparam int FLAG_IO     = 3;
   localparam logic [FLAG_W-1:0] FLAGS_RESET = 4'b1011;

   localparam logic [3:0] PAGE_ZERO   = 4'h0;
   localparam logic [3:0] PAGE_IO     = 4'hD;
   localparam logic [3:0] PAGE_CART   = 4'h8;
   localparam logic [3:0] PAGE_BASIC  = 4'hA;
   localparam logic [3:0] PAGE_BASIC2 = 4'hB;
   localparam logic [3:0] PAGE_KERNAL = 4'hE;

   localparam logic [CSR_IDX_W-1:0] CSR_CART_PRESENT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CART_IO      = 1'b1;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_LOAD  = 2'd2
   } cmd_type;

   typedef enum logic [ROUTE_W-1:0] {
      ROUTE_RAM   = 4'd0,
      ROUTE_ROM   = 4'd1,
      ROUTE_PORT  = 4'd2,
      ROUTE_COLOR = 4'd3,
      ROUTE_VIC   = 4'd4,
      ROUTE_SID   = 4'd5,
      ROUTE_CIA1  = 4'd6,
      ROUTE_CIA2  = 4'd7,
      ROUTE_OPEN  = 4'd8,
      ROUTE_CART  = 4'd9,
      ROUTE_DROP  = 4'd10
   } route_type;

   typedef enum logic [2:0] {
      SRC_NONE  = 3'd0,
      SRC_RAM   = 3'd1,
      SRC_ROM   = 3'd2,
      SRC_COLOR = 3'd3,
      SRC_CONST = 3'd4
   } src_type;

   typedef struct packed {
      route_type           route;
      logic [ADDR_W-1:0]   dev_addr;
      src_type             src;
      logic [DATA_W-1:0]   cdata;
      logic                ram_re;
      logic                ram_we;
      logic                rom_re;
      logic                rom_we;
      logic                col_re;
      logic                col_we;
      logic                dir_we;
      logic                pdata_we;
   } dec_type;

   function automatic logic [DATA_W-1:0] port_lines(input logic [DATA_W-1:0] dir,
                                                    input logic [DATA_W-1:0] pdata,
                                                    input logic [DATA_W-1:0] ext);
      port_lines = (dir & pdata) | (~dir & ext);
   endfunction

   function automatic logic [FLAG_W-1:0] flags_from_lines(input logic [DATA_W-1:0] lines);
      logic any;
      logic [FLAG_W-1:0] f;
      any = lines[1] | lines[0];
      f[FLAG_KERNAL] = lines[1];
      f[FLAG_BASIC]  = lines[1] & lines[0];
      f[FLAG_CHAR]   = ~lines[2] & any;
      f[FLAG_IO]     = lines[2] & any;
      flags_from_lines = f;
   endfunction

endpackage

// File: hw/rtl/hcbd_ram.sv
// ----------------------------------------------------------------------------
// Bank decoder single-port RAM
// Synchronous write and registered read; the read register holds its value
// while no read is issued.
// ----------------------------------------------------------------------------
module hcbd_ram #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              we,
   input  logic              re,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/hcbd_decode.sv
// ----------------------------------------------------------------------------
// Bank decoder access decode
// Maps one bus access onto a route, a device address, a read source and
// the memory and port register strobes, from the current bank flags.
// ----------------------------------------------------------------------------
module hcbd_decode (
   input  hcbd_pkg::cmd_type                 cmd,
   input  logic [hcbd_pkg::ADDR_W-1:0]       address,
   input  logic [hcbd_pkg::DATA_W-1:0]       port_external,
   input  logic [hcbd_pkg::DATA_W-1:0]       vic_bus,
   input  logic                              cart_claims,
   input  logic [hcbd_pkg::FLAG_W-1:0]       flags,
   input  logic [hcbd_pkg::DATA_W-1:0]       port_dir,
   input  logic [hcbd_pkg::DATA_W-1:0]       port_data,
   input  logic                              cart_present,
   input  logic                              cart_io_enabled,
   output hcbd_pkg::dec_type                 dec
);

   logic [3:0] page;
   logic [3:0] sub;
   logic       basic_pg;
   logic       kernal_pg;
   logic       cart_pg;
   logic       io_on;

   assign page      = address[15:12];
   assign sub       = address[11:8];
   assign basic_pg  = (page == hcbd_pkg::PAGE_BASIC) || (page == hcbd_pkg::PAGE_BASIC2);
   assign kernal_pg = (page >= hcbd_pkg::PAGE_KERNAL);
   assign cart_pg   = ((page >= hcbd_pkg::PAGE_CART) && (page <= hcbd_pkg::PAGE_BASIC2))
                      || kernal_pg;
   assign io_on     = flags[hcbd_pkg::FLAG_IO];

   always_comb begin
      dec          = '0;
      dec.route    = hcbd_pkg::ROUTE_DROP;
      dec.src      = hcbd_pkg::SRC_NONE;
      case (cmd)
         hcbd_pkg::CMD_READ: begin
            if (page == hcbd_pkg::PAGE_ZERO) begin
               if (address == 16'h0000) begin
                  dec.route = hcbd_pkg::ROUTE_PORT;
                  dec.src   = hcbd_pkg::SRC_CONST;
                  dec.cdata = port_dir;
               end else if (address == 16'h0001) begin
                  dec.route = hcbd_pkg::ROUTE_PORT;
                  dec.src   = hcbd_pkg::SRC_CONST;
                  dec.cdata = hcbd_pkg::port_lines(port_dir, port_data, port_external);
               end else begin
                  dec.route  = hcbd_pkg::ROUTE_RAM;
                  dec.src    = hcbd_pkg::SRC_RAM;
                  dec.ram_re = 1'b1;
               end
            end else if (page == hcbd_pkg::PAGE_IO) begin
               if (io_on) begin
                  if (sub <= 4'h3) begin
                     dec.route    = hcbd_pkg::ROUTE_VIC;
                     dec.dev_addr = {10'd0, address[5:0]};
                  end else if (sub <= 4'h7) begin
                     dec.route    = hcbd_pkg::ROUTE_SID;
                     dec.dev_addr = {11'd0, address[4:0]};
                  end else if (sub <= 4'hB) begin
                     dec.route  = hcbd_pkg::ROUTE_COLOR;
                     dec.src    = hcbd_pkg::SRC_COLOR;
                     dec.cdata  = vic_bus;
                     dec.col_re = 1'b1;
                  end else if (sub == 4'hC) begin
                     dec.route    = hcbd_pkg::ROUTE_CIA1;
                     dec.dev_addr = {12'd0, address[3:0]};
                  end else if (sub == 4'hD) begin
                     dec.route    = hcbd_pkg::ROUTE_CIA2;
                     dec.dev_addr = {12'd0, address[3:0]};
                  end else begin
                     dec.route = hcbd_pkg::ROUTE_OPEN;
                     dec.src   = hcbd_pkg::SRC_CONST;
                     dec.cdata = vic_bus;
                  end
               end else if (flags[hcbd_pkg::FLAG_CHAR]) begin
                  dec.route  = hcbd_pkg::ROUTE_ROM;
                  dec.src    = hcbd_pkg::SRC_ROM;
                  dec.rom_re = 1'b1;
               end else begin
                  dec.route  = hcbd_pkg::ROUTE_RAM;
                  dec.src    = hcbd_pkg::SRC_RAM;
                  dec.ram_re = 1'b1;
               end
            end else if (cart_present && cart_pg && cart_claims) begin
               dec.route    = hcbd_pkg::ROUTE_CART;
               dec.dev_addr = address;
            end else if ((basic_pg && flags[hcbd_pkg::FLAG_BASIC])
                         || (kernal_pg && flags[hcbd_pkg::FLAG_KERNAL])) begin
               dec.route  = hcbd_pkg::ROUTE_ROM;
               dec.src    = hcbd_pkg::SRC_ROM;
               dec.rom_re = 1'b1;
            end else begin
               dec.route  = hcbd_pkg::ROUTE_RAM;
               dec.src    = hcbd_pkg::SRC_RAM;
               dec.ram_re = 1'b1;
            end
         end
         hcbd_pkg::CMD_WRITE: begin
            if (address == 16'h0000) begin
               dec.route  = hcbd_pkg::ROUTE_PORT;
               dec.dir_we = 1'b1;
            end else if (address == 16'h0001) begin
               dec.route    = hcbd_pkg::ROUTE_PORT;
               dec.pdata_we = 1'b1;
            end else if ((page == hcbd_pkg::PAGE_IO) && io_on) begin
               if (sub <= 4'h3) begin
                  dec.route    = hcbd_pkg::ROUTE_VIC;
                  dec.dev_addr = {10'd0, address[5:0]};
               end else if (sub <= 4'h7) begin
                  dec.route    = hcbd_pkg::ROUTE_SID;
                  dec.dev_addr = {11'd0, address[4:0]};
               end else if (sub <= 4'hB) begin
                  dec.route  = hcbd_pkg::ROUTE_COLOR;
                  dec.col_we = 1'b1;
               end else if (sub == 4'hC) begin
                  dec.route    = hcbd_pkg::ROUTE_CIA1;
                  dec.dev_addr = {12'd0, address[3:0]};
               end else if (sub == 4'hD) begin
                  dec.route    = hcbd_pkg::ROUTE_CIA2;
                  dec.dev_addr = {12'd0, address[3:0]};
               end else if (cart_present && cart_io_enabled) begin
                  dec.route    = hcbd_pkg::ROUTE_CART;
                  dec.dev_addr = address;
               end else begin
                  dec.route = hcbd_pkg::ROUTE_DROP;
               end
            end else begin
               dec.route  = hcbd_pkg::ROUTE_RAM;
               dec.ram_we = 1'b1;
            end
         end
         hcbd_pkg::CMD_LOAD: begin
            if (cart_present && cart_claims) begin
               dec.route    = hcbd_pkg::ROUTE_CART;
               dec.dev_addr = address;
            end else begin
               dec.route  = hcbd_pkg::ROUTE_ROM;
               dec.rom_we = 1'b1;
            end
         end
         default: begin
            dec.route = hcbd_pkg::ROUTE_DROP;
         end
      endcase
   end

endmodule

// File: hw/rtl/home_computer_bank_decoder_top.sv
// ----------------------------------------------------------------------------
// Path: an accepted request is registered in the memory read stage and then in
// the output register, which drives rsp_tvalid.
// Throughput: one access per cycle unless the output stalls or RAM is cleared;
// each single-port memory answers a read in the cycle after it is issued.
// Reset: synchronous, active high; afterwards main RAM is cleared one byte a
// cycle, every address, with req_tready low; CSR writes are taken throughout.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// Home computer bank decoder
// Processor port, bank flags, main RAM, ROM image and color RAM with a
// decode stage, a memory read stage and an output register.
// ----------------------------------------------------------------------------
module home_computer_bank_decoder_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [hcbd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic                            csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // address[15:0], write_data[23:16], port_external[31:24], vic_bus[39:32]
   input  logic [39:0]                     req_tdata,
   // cmd[1:0], cart_claims[2]
   input  logic [2:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // read_data[7:0], device_address[23:8]
   output logic [23:0]                     rsp_tdata,
   // read_valid[0], route[4:1]
   output logic [4:0]                      rsp_tuser
);

   logic [hcbd_pkg::ADDR_W-1:0] address;
   logic [hcbd_pkg::DATA_W-1:0] write_data;
   logic [hcbd_pkg::DATA_W-1:0] port_external;
   logic [hcbd_pkg::DATA_W-1:0] vic_bus;
   hcbd_pkg::dec_type           dec;
   logic                        accept;
   logic                        out_free;

   logic                        cart_present_ff;
   logic                        cart_io_ff;
   logic [hcbd_pkg::DATA_W-1:0] port_dir_ff, port_dir_in;
   logic [hcbd_pkg::DATA_W-1:0] port_data_ff, port_data_in;
   logic [hcbd_pkg::FLAG_W-1:0] flags_ff, flags_in;

   logic                        clear_ff, clear_in;
   logic [hcbd_pkg::ADDR_W-1:0] clear_cnt_ff, clear_cnt_in;

   logic                        s1_valid_ff, s1_valid_in;
   hcbd_pkg::route_type         s1_route_ff;
   logic [hcbd_pkg::ADDR_W-1:0] s1_dev_ff;
   hcbd_pkg::src_type           s1_src_ff;
   logic [hcbd_pkg::DATA_W-1:0] s1_cdata_ff;

   logic                        out_valid_ff, out_valid_in;
   logic [hcbd_pkg::DATA_W-1:0] out_data_ff, out_data_in;
   logic                        out_rvalid_ff, out_rvalid_in;
   logic [hcbd_pkg::ROUTE_W-1:0] out_route_ff;
   logic [hcbd_pkg::ADDR_W-1:0] out_dev_ff;

   logic                        ram_we;
   logic [hcbd_pkg::ADDR_W-1:0] ram_addr;
   logic [hcbd_pkg::DATA_W-1:0] ram_wdata;
   logic [hcbd_pkg::DATA_W-1:0] ram_rdata;
   logic [hcbd_pkg::DATA_W-1:0] rom_rdata;
   logic [hcbd_pkg::COLOR_DW-1:0] col_rdata;

   assign address       = req_tdata[15:0];
   assign write_data    = req_tdata[23:16];
   assign port_external = req_tdata[31:24];
   assign vic_bus       = req_tdata[39:32];

   hcbd_decode u_decode (
      .cmd             (hcbd_pkg::cmd_type'(req_tuser[1:0])),
      .address         (address),
      .port_external   (port_external),
      .vic_bus         (vic_bus),
      .cart_claims     (req_tuser[2]),
      .flags           (flags_ff),
      .port_dir        (port_dir_ff),
      .port_data       (port_data_ff),
      .cart_present    (cart_present_ff),
      .cart_io_enabled (cart_io_ff),
      .dec             (dec)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = !clear_ff && (!s1_valid_ff || out_free);
   assign accept     = req_tvalid && req_tready;

   assign ram_we    = clear_ff || (accept && dec.ram_we);
   assign ram_addr  = clear_ff ? clear_cnt_ff : address;
   assign ram_wdata = clear_ff ? '0 : write_data;

   hcbd_ram #(.ADDR_W(hcbd_pkg::ADDR_W), .DATA_W(hcbd_pkg::DATA_W)) u_main_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (accept && dec.ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   hcbd_ram #(.ADDR_W(hcbd_pkg::ADDR_W), .DATA_W(hcbd_pkg::DATA_W)) u_rom_image (
      .clock (clock),
      .we    (accept && dec.rom_we),
      .re    (accept && dec.rom_re),
      .addr  (address),
      .wdata (write_data),
      .rdata (rom_rdata)
   );

   hcbd_ram #(.ADDR_W(hcbd_pkg::COLOR_AW), .DATA_W(hcbd_pkg::COLOR_DW)) u_color_ram (
      .clock (clock),
      .we    (accept && dec.col_we),
      .re    (accept && dec.col_re),
      .addr  (address[hcbd_pkg::COLOR_AW-1:0]),
      .wdata (write_data[hcbd_pkg::COLOR_DW-1:0]),
      .rdata (col_rdata)
   );

   always_comb begin
      port_dir_in  = port_dir_ff;
      port_data_in = port_data_ff;
      flags_in     = flags_ff;
      if (accept && dec.dir_we) begin
         port_dir_in = write_data;
      end
      if (accept && dec.pdata_we) begin
         port_data_in = write_data;
      end
      if (accept && (dec.dir_we || dec.pdata_we)) begin
         flags_in = hcbd_pkg::flags_from_lines(
            hcbd_pkg::port_lines(port_dir_in, port_data_in, port_external));
      end
   end

   always_comb begin
      clear_in     = clear_ff;
      clear_cnt_in = clear_cnt_ff;
      if (clear_ff) begin
         clear_cnt_in = clear_cnt_ff + 1'b1;
         if (clear_cnt_ff == '1) begin
            clear_in = 1'b0;
         end
      end
   end

   always_comb begin
      case (s1_src_ff)
         hcbd_pkg::SRC_RAM: begin
            out_data_in   = ram_rdata;
            out_rvalid_in = 1'b1;
         end
         hcbd_pkg::SRC_ROM: begin
            out_data_in   = rom_rdata;
            out_rvalid_in = 1'b1;
         end
         hcbd_pkg::SRC_COLOR: begin
            out_data_in   = {s1_cdata_ff[7:4], col_rdata};
            out_rvalid_in = 1'b1;
         end
         hcbd_pkg::SRC_CONST: begin
            out_data_in   = s1_cdata_ff;
            out_rvalid_in = 1'b1;
         end
         default: begin
            out_data_in   = '0;
            out_rvalid_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_valid_ff && out_free) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cart_present_ff <= 1'b0;
         cart_io_ff      <= 1'b0;
         port_dir_ff     <= hcbd_pkg::PORT_DIR_RESET;
         port_data_ff    <= hcbd_pkg::PORT_DATA_RESET;
         flags_ff        <= hcbd_pkg::FLAGS_RESET;
         clear_ff        <= 1'b1;
         clear_cnt_ff    <= '0;
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (csr_we && (csr_index == hcbd_pkg::CSR_CART_PRESENT)) begin
            cart_present_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == hcbd_pkg::CSR_CART_IO)) begin
            cart_io_ff <= csr_wdata;
         end
         port_dir_ff  <= port_dir_in;
         port_data_ff <= port_data_in;
         flags_ff     <= flags_in;
         clear_ff     <= clear_in;
         clear_cnt_ff <= clear_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_route_ff <= dec.route;
         s1_dev_ff   <= dec.dev_addr;
         s1_src_ff   <= dec.src;
         s1_cdata_ff <= dec.cdata;
      end
      if (s1_valid_ff && out_free) begin
         out_data_ff   <= out_data_in;
         out_rvalid_ff <= out_rvalid_in;
         out_route_ff  <= s1_route_ff;
         out_dev_ff    <= s1_dev_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_dev_ff, out_data_ff};
   assign rsp_tuser  = {out_route_ff, out_rvalid_ff};

endmodule

// File: hw/rtl/hcbd_checker.sv
// ----------------------------------------------------------------------------
// Bank decoder port checker
// Watches the top-level ports for result consistency and reset behavior.
// ----------------------------------------------------------------------------
module hcbd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [4:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Stalled result changed before its transfer.");

   a_no_data_without_read: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[7:0] == 8'd0)
      else $error("Read data is nonzero on a result without a read answer.");

   a_vic_mirror: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[4:1] == hcbd_pkg::ROUTE_VIC) |-> rsp_tdata[23:14] == 10'd0)
      else $error("Video chip device address is not mirrored into its register window.");

   a_internal_no_dev: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[23:8] == 16'd0)
      else $error("Internally served read carries a device address.");

   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_tready)
      else $error("Requests accepted before the RAM clearing pass.");

endmodule

bind home_computer_bank_decoder_top hcbd_checker u_hcbd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: dv/tb_home_computer_bank_decoder_top.sv
// ----------------------------------------------------------------------------
// Bank decoder testbench
// A directed table followed by random phases under every cartridge setting.
// Each access is predicted in order by a local memory-map model. Each result
// transfer is then compared field by field with the oldest expected outcome,
// the table's own for typed rows, while both sides of the stream stall at random.
// ----------------------------------------------------------------------------
module tb_home_computer_bank_decoder_top;
   import hcbd_pkg::*;

   localparam logic [1:0] CMD_RESERVED = 2'd3;
   localparam int N_ROWS = 30;
   localparam int N_PHASES = 5;
   localparam int PHASE_ITEMS = 170;

   typedef enum logic {
      ROW_ACCESS,
      ROW_CART
   } row_kind_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] addr;
      logic [7:0]  wdata;
      logic [7:0]  ext;
      logic [7:0]  vbus;
      logic        claims;
   } access_type;

   typedef struct packed {
      logic [7:0]  data;
      logic        valid;
      route_type   route;
      logic [15:0] dev;
   } outcome_type;

   // A cartridge row takes cart_present from wdata[0] and cart_io_enabled from wdata[1].
   typedef struct packed {
      row_kind_type kind;
      logic         typed;
      access_type   acc;
      outcome_type  want;
   } row_type;

   localparam row_type DIRECTED_ROWS [0:N_ROWS-1] = '{
      '{ROW_ACCESS, 1'b1, '{CMD_READ, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0},
        '{8'h2F, 1'b1, ROUTE_PORT, 16'h0000}},
      '{ROW_ACCESS, 1'b1, '{CMD_READ, 16'h0001, 8'h00, 8'h00, 8'h00, 1'b0},
        '{8'h0F, 1'b1, ROUTE_PORT, 16'h0000}},
      '{ROW_ACCESS, 1'b0, '{CMD_READ, 16'h0001, 8'h00, 8'hFF, 8'hFF, 1'b1},
        '{8'h00, 1'b0, ROUTE_RAM, 16'h0000}},
      '{ROW_ACCESS, 1'b1, '{CMD_READ, 16'h0002, 8'h00, 8'h00, 8'h00, 1'b0},
        '{8'h00, 1'b1, ROUTE_RAM, 16'h0000}},
      '{ROW_ACCESS, 1'b1, '{CMD_READ, 16'hD000, 8'h00, 8'h00, 8'h00, 1'b0},
        '{8'h00, 1'b0, ROUTE_VIC, 16'h0000}},
      '{ROW_ACCESS, 1'b1, '{CMD_READ, 16'hD7FF, 8'h00, 8'h00, 8'h00, 1'b0},
        '{8'h00, 1'b0, ROUTE_SID, 16'h001F}},
      '{ROW_ACCESS, 1'b1, '{CMD_READ, 16'hDCFF, 8'h00, 8'h00, 8'h00, 1'b0},
        '{8'h00, 1'b0, ROUTE_CIA1, 16'h000F}},
      '{ROW_ACCESS, 1'b1, '{CMD_READ, 16'hDDFF, 8'h00, 8'h00, 8'h00, 1'b0},
        '{8'h00, 1'b0, ROUTE_CIA2, 16'h000F}},
      '{ROW_ACCESS, 1'b1, '{CMD_READ, 16'hDE00, 8'h00, 8'h00, 8'hA5, 1'b0},
        '{8'hA5, 1'b1, ROUTE_OPEN, 16'h0000}},
      '{ROW_ACCESS, 1'b1, '{CMD_WRITE, 16'hDFFF, 8'hFF, 8'h00, 8'h00, 1'b0},
        '{8'h00, 1'b0, ROUTE_DROP, 16'h0000}},
      '{ROW_ACCESS, 1'b1, '{CMD_RESERVED, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1},
        '{8'h00, 1'b0, ROUTE_DROP, 16'h0000}},
      '{ROW_ACCESS, 1'b1, '{CMD_LOAD, 16'hFFFF, 8'hFF, 8'h00, 8'h00, 1'b0},
        '{8'h00, 1'b0, ROUTE_ROM, 16'h0000}},
      '{ROW_ACCESS, 1'b1, '{CMD_READ, 16'hFFFF, 8'h00, 8'h00, 8'h00, 1'b0},
        '{8'hFF, 1'b1, ROUTE_ROM, 16'h0000}},
      '{ROW_ACCESS, 1'b1, '{CMD_WRITE, 16'hFFFF, 8'h5A, 8'h00, 8'h00, 1'b0},
        '{8'h00, 1'b0, ROUTE_RAM, 16'h0000}},
      '{ROW_ACCESS, 1'b1, '{CMD_WRITE, 16'hD800, 8'hFF, 8'h00, 8'h00, 1'b0},
        '{8'h00, 1'b0, ROUTE_COLOR, 16'h0000}},
      '{ROW_ACCESS, 1'b0, '{CMD_READ, 16'hD800, 8'h00, 8'h00, 8'h30, 1'b0},
        '{8'h00, 1'b0, ROUTE_RAM, 16'h0000}},
      '{ROW_ACCESS, 1'b1, '{CMD_LOAD, 16'hD000, 8'h80, 8'h00, 8'h00, 1'b0},
        '{8'h00, 1'b0, ROUTE_ROM, 16'h0000}},
      '{ROW_ACCESS, 1'b1, '{CMD_WRITE, 16'h0000, 8'hFF, 8'h00, 8'h00, 1'b0},
        '{8'h00, 1'b0, ROUTE_PORT, 16'h0000}},
      '{ROW_ACCESS, 1'b1, '{CMD_WRITE, 16'h0001, 8'h00, 8'h00, 8'h00, 1'b0},
        '{8'h00, 1'b0, ROUTE_PORT, 16'h0000}},
      '{ROW_ACCESS, 1'b1, '{CMD_READ, 16'hFFFF, 8'h00, 8'h00, 8'h00, 1'b0},
        '{8'h5A, 1'b1, ROUTE_RAM, 16'h0000}},
      '{ROW_ACCESS, 1'b1, '{CMD_WRITE, 16'h0001, 8'h03, 8'h00, 8'h00, 1'b0},
        '{8'h00, 1'b0, ROUTE_PORT, 16'h0000}},
      '{ROW_ACCESS, 1'b1, '{CMD_READ, 16'hD000, 8'h00, 8'h00, 8'h00, 1'b0},
        '{8'h80, 1'b1, ROUTE_ROM, 16'h0000}},
      '{ROW_ACCESS, 1'b1, '{CMD_WRITE, 16'h0001, 8'h07, 8'h00, 8'h00, 1'b0},
        '{8'h00, 1'b0, ROUTE_PORT, 16'h0000}},
      '{ROW_CART, 1'b0, '{CMD_READ, 16'h0000, 8'h03, 8'h00, 8'h00, 1'b0},
        '{8'h00, 1'b0, ROUTE_RAM, 16'h0000}},
      '{ROW_ACCESS, 1'b1, '{CMD_READ, 16'h8000, 8'h00, 8'h00, 8'h00, 1'b1},
        '{8'h00, 1'b0, ROUTE_CART, 16'h8000}},
      '{ROW_ACCESS, 1'b1, '{CMD_READ, 16'h8000, 8'h00, 8'h00, 8'h00, 1'b0},
        '{8'h00, 1'b1, ROUTE_RAM, 16'h0000}},
      '{ROW_ACCESS, 1'b1, '{CMD_WRITE, 16'hDE00, 8'h11, 8'h00, 8'h00, 1'b0},
        '{8'h00, 1'b0, ROUTE_CART, 16'hDE00}},
      '{ROW_ACCESS, 1'b1, '{CMD_LOAD, 16'hA000, 8'h22, 8'h00, 8'h00, 1'b1},
        '{8'h00, 1'b0, ROUTE_CART, 16'hA000}},
      '{ROW_CART, 1'b0, '{CMD_READ, 16'h0000, 8'h01, 8'h00, 8'h00, 1'b0},
        '{8'h00, 1'b0, ROUTE_RAM, 16'h0000}},
      '{ROW_ACCESS, 1'b1, '{CMD_WRITE, 16'hDE00, 8'h33, 8'h00, 8'h00, 1'b0},
        '{8'h00, 1'b0, ROUTE_DROP, 16'h0000}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic        csr_wdata = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [4:0]  rsp_tuser;

   logic [7:0]  main_mem [0:65535];
   logic [7:0]  rom_mem [0:65535];
   bit          rom_loaded [0:65535];
   logic [3:0]  color_mem [0:1023];
   bit          color_loaded [0:1023];
   logic [7:0]  port_dir = PORT_DIR_RESET;
   logic [7:0]  port_out = PORT_DATA_RESET;
   logic        show_kernal = FLAGS_RESET[FLAG_KERNAL];
   logic        show_basic = FLAGS_RESET[FLAG_BASIC];
   logic        show_char = FLAGS_RESET[FLAG_CHAR];
   logic        show_io = FLAGS_RESET[FLAG_IO];
   logic        cart_on = 1'b0;
   logic        cart_io_on = 1'b0;
   logic        req_steady = 1'b0;

   outcome_type expected_outcomes [$];
   logic [15:0] recent_addrs [$];
   int          error_count = 0;

   home_computer_bank_decoder_top DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] port_levels(input logic [7:0] ext);
      return (port_dir & port_out) | (~port_dir & ext);
   endfunction

   function automatic route_type io_area(input logic [15:0] a);
      if (a <= 16'hD3FF) return ROUTE_VIC;
      if (a <= 16'hD7FF) return ROUTE_SID;
      if (a <= 16'hDBFF) return ROUTE_COLOR;
      if (a <= 16'hDCFF) return ROUTE_CIA1;
      if (a <= 16'hDDFF) return ROUTE_CIA2;
      return ROUTE_OPEN;
   endfunction

   function automatic logic [15:0] device_offset(input route_type r, input logic [15:0] a);
      case (r)
         ROUTE_VIC:  return a & 16'h003F;
         ROUTE_SID:  return a & 16'h001F;
         ROUTE_CIA1: return a & 16'h000F;
         ROUTE_CIA2: return a & 16'h000F;
         ROUTE_CART: return a;
         default:    return 16'h0000;
      endcase
   endfunction

   function automatic route_type read_target(input logic [15:0] a, input logic claims);
      logic [3:0] page;
      logic basic_pg;
      logic kernal_pg;
      logic cart_pg;
      page = a[15:12];
      basic_pg = (page == PAGE_BASIC) || (page == PAGE_BASIC2);
      kernal_pg = (page >= PAGE_KERNAL);
      cart_pg = (page >= PAGE_CART && page <= PAGE_BASIC2) || kernal_pg;
      if (page == PAGE_ZERO) return (a <= 16'h0001) ? ROUTE_PORT : ROUTE_RAM;
      if (page == PAGE_IO) begin
         if (show_io) return io_area(a);
         return show_char ? ROUTE_ROM : ROUTE_RAM;
      end
      if (cart_on && cart_pg && claims) return ROUTE_CART;
      if ((basic_pg && show_basic) || (kernal_pg && show_kernal)) return ROUTE_ROM;
      return ROUTE_RAM;
   endfunction

   function automatic outcome_type predict_access(input access_type acc);
      outcome_type o;
      logic [7:0] lines;
      o = '{8'h00, 1'b0, ROUTE_DROP, 16'h0000};
      lines = port_levels(acc.ext);
      case (acc.cmd)
         CMD_READ: begin
            o.route = read_target(acc.addr, acc.claims);
            o.valid = 1'b1;
            case (o.route)
               ROUTE_PORT:  o.data = acc.addr[0] ? lines : port_dir;
               ROUTE_RAM:   o.data = main_mem[acc.addr];
               ROUTE_ROM:   o.data = rom_mem[acc.addr];
               ROUTE_COLOR: o.data = {acc.vbus[7:4], color_mem[acc.addr[9:0]]};
               ROUTE_OPEN:  o.data = acc.vbus;
               default: begin
                  o.valid = 1'b0;
                  o.dev = device_offset(o.route, acc.addr);
               end
            endcase
         end
         CMD_WRITE: begin
            if (acc.addr <= 16'h0001) begin
               if (acc.addr[0]) port_out = acc.wdata;
               else port_dir = acc.wdata;
               lines = port_levels(acc.ext);
               show_kernal = lines[1];
               show_basic = lines[1] & lines[0];
               show_char = !lines[2] && (lines[1:0] != 2'b00);
               show_io = lines[2] && (lines[1:0] != 2'b00);
               o.route = ROUTE_PORT;
            end else if (acc.addr[15:12] == PAGE_IO && show_io) begin
               o.route = io_area(acc.addr);
               if (o.route == ROUTE_COLOR) begin
                  color_mem[acc.addr[9:0]] = acc.wdata[3:0];
                  color_loaded[acc.addr[9:0]] = 1'b1;
               end else if (o.route == ROUTE_OPEN) begin
                  o.route = (cart_on && cart_io_on) ? ROUTE_CART : ROUTE_DROP;
               end
               o.dev = device_offset(o.route, acc.addr);
            end else begin
               main_mem[acc.addr] = acc.wdata;
               o.route = ROUTE_RAM;
            end
         end
         CMD_LOAD: begin
            if (cart_on && acc.claims) begin
               o.route = ROUTE_CART;
               o.dev = acc.addr;
            end else begin
               rom_mem[acc.addr] = acc.wdata;
               rom_loaded[acc.addr] = 1'b1;
               o.route = ROUTE_ROM;
            end
         end
         default: o.route = ROUTE_DROP;
      endcase
      return o;
   endfunction

   // Reads that would hit an unloaded ROM or color entry are turned into the
   // access that fills that entry.
   function automatic access_type draw_access();
      access_type acc;
      int pick;
      route_type r;
      acc.wdata = 8'($urandom);
      acc.ext = 8'($urandom);
      acc.vbus = 8'($urandom);
      acc.claims = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 45) acc.cmd = CMD_READ;
      else if (pick < 78) acc.cmd = CMD_WRITE;
      else if (pick < 96) acc.cmd = CMD_LOAD;
      else acc.cmd = CMD_RESERVED;
      pick = $urandom_range(0, 99);
      if (pick < 10) acc.addr = 16'($urandom_range(0, 1));
      else if (pick < 40 && recent_addrs.size() > 0)
         acc.addr = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
      else if (pick < 60) acc.addr = {PAGE_IO, 12'($urandom)};
      else if (pick < 75) acc.addr = {($urandom_range(0, 1) ? 3'b111 : 3'b101), 13'($urandom)};
      else acc.addr = 16'($urandom);
      if (acc.cmd == CMD_READ) begin
         r = read_target(acc.addr, acc.claims);
         if (r == ROUTE_ROM && !rom_loaded[acc.addr]) begin
            acc.cmd = CMD_LOAD;
            acc.claims = 1'b0;
         end else if (r == ROUTE_COLOR && !color_loaded[acc.addr[9:0]]) begin
            acc.cmd = CMD_WRITE;
         end
      end
      recent_addrs.push_back(acc.addr);
      if (recent_addrs.size() > 48) void'(recent_addrs.pop_front());
      return acc;
   endfunction

   task automatic send_access(input access_type acc, input logic typed, input outcome_type want);
      outcome_type calc;
      int gap;
      calc = predict_access(acc);
      gap = req_steady ? 0 : $urandom_range(0, 3);
      if ($urandom_range(0, 31) == 0) req_steady = !req_steady;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      expected_outcomes.push_back(typed ? want : calc);
      req_tvalid <= 1'b1;
      req_tdata <= {acc.vbus, acc.ext, acc.wdata, acc.addr};
      req_tuser <= {acc.claims, acc.cmd};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_cartridge(input logic present, input logic io);
      csr_we <= 1'b1;
      csr_index <= CSR_CART_PRESENT;
      csr_wdata <= present;
      @(posedge clock);
      csr_index <= CSR_CART_IO;
      csr_wdata <= io;
      @(posedge clock);
      csr_we <= 1'b0;
      cart_on = present;
      cart_io_on = io;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   initial begin : response_side
      outcome_type got;
      outcome_type want;
      int gap;
      logic steady;
      steady = 1'b0;
      @(negedge reset);
      forever begin
         gap = steady ? 0 : $urandom_range(0, 3);
         if ($urandom_range(0, 31) == 0) steady = !steady;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(negedge clock); while (!rsp_tvalid);
         got.data = rsp_tdata[7:0];
         got.dev = rsp_tdata[23:8];
         got.valid = rsp_tuser[0];
         got.route = route_type'(rsp_tuser[4:1]);
         @(posedge clock);
         if (expected_outcomes.size() == 0) begin
            report_mismatch("unexpected transfer, route", got.route, 0);
         end else begin
            want = expected_outcomes.pop_front();
            if (got.data != want.data) report_mismatch("read_data", got.data, want.data);
            if (got.valid != want.valid) report_mismatch("read_valid", got.valid, want.valid);
            if (got.route != want.route) report_mismatch("route", got.route, want.route);
            if (got.dev != want.dev) report_mismatch("device_address", got.dev, want.dev);
         end
      end
   end

   initial begin : stimulus
      outcome_type none;
      logic [1:0] settings [0:N_PHASES-1];
      int i;
      none = '0;
      settings = '{2'b00, 2'b01, 2'b10, 2'b11, 2'b00};
      for (i = 0; i < 65536; i++) main_mem[i] = 8'h00;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (i = 0; i < N_ROWS; i++) begin
         if (DIRECTED_ROWS[i].kind == ROW_CART) begin
            drain_responses();
            set_cartridge(DIRECTED_ROWS[i].acc.wdata[0], DIRECTED_ROWS[i].acc.wdata[1]);
         end else begin
            send_access(DIRECTED_ROWS[i].acc, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
         end
      end
      for (i = 0; i < N_PHASES; i++) begin
         drain_responses();
         set_cartridge(settings[i][0], settings[i][1]);
         repeat (PHASE_ITEMS) send_access(draw_access(), 1'b0, none);
      end
      drain_responses();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_home_computer_bank_decoder_top: clean");
      end else begin
         $display("tb_home_computer_bank_decoder_top: errors");
      end
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("tb_home_computer_bank_decoder_top: errors");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/hcbd_pkg.sv
hw/rtl/hcbd_ram.sv
hw/rtl/hcbd_decode.sv
hw/rtl/home_computer_bank_decoder_top.sv
hw/rtl/hcbd_checker.sv
dv/tb_home_computer_bank_decoder_top.sv
